// File: design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and the CRC byte update for the packet framer.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [7:0]  MAGIC_RESET = 8'h69;

   // Header beats ahead of the payload: magic, descriptor, 4 timestamp bytes
   localparam int HDR_BYTES = 6;

   typedef struct packed {
      logic write;   // payload beat accepted
      logic emit;    // load next frame beat into the output register
   } cmd_type;

   typedef struct packed {
      logic fill_last;  // current write completes the payload
      logic pos_last;   // current frame beat is the CRC high byte
   } status_type;

   // CRC16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: design/payload_packet_framer_crc16.sv
// ----------------------------------------------------------------------------
// payload_packet_framer_crc16
// Collects payload beats into a packet and sends it framed with a CRC16.
// ----------------------------------------------------------------------------
// Each accepted req beat carries one payload byte. The first beat of a packet
// also captures its descriptor and timestamp; those fields are ignored on
// later beats. Once PAYLOAD_BYTES beats are in, the block sends the frame on
// rsp, one byte per beat: the magic byte (csr register, reset 0x69), the
// descriptor, the timestamp LSB first, the payload in arrival order, then the
// CRC16-CCITT (init 0xFFFF, poly 0x1021, MSB first, no final xor) over all
// preceding frame bytes, low byte then high byte. rsp_frame_last marks the
// CRC high byte. Rate: payload beats are taken one per cycle; the frame then
// goes out at one beat per cycle while rsp_ready is held, and req_ready stays
// low until the last frame byte is loaded into the output register, so a new
// packet is not taken while a frame is still going out. A single frame
// sequencer walks the payload RAM's read port and the CRC unit one byte per
// frame beat. Write csr only while the block is idle.
// ----------------------------------------------------------------------------
module payload_packet_framer_crc16 #(
   parameter int PAYLOAD_BYTES = 48
) (
   input  logic        clock,
   input  logic        reset,
   // payload input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_descriptor,
   input  logic [31:0] req_timestamp,
   // framed output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_last,
   // magic byte register
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   pfc_pkg::cmd_type    cmd;
   pfc_pkg::status_type status;

   // sequencing: collect beats, then walk the frame
   pfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, byte select and CRC
   pfc_dp #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_data_byte  (req_data_byte),
      .req_descriptor (req_descriptor),
      .req_timestamp  (req_timestamp),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// File: design/pfc_ram.sv
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// pfc_ctrl
// Collect/emit state machine and output valid for the packet framer.
// ----------------------------------------------------------------------------
module pfc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pfc_pkg::status_type status,
   output pfc_pkg::cmd_type    cmd
);

   localparam logic ST_COLLECT = 1'b0;
   localparam logic ST_EMIT    = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load;

   assign req_ready = (state_ff == ST_COLLECT);
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign cmd.write = req_valid && req_ready;
   assign cmd.emit  = load;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (cmd.write && status.fill_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load && status.pos_last) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/pfc_dp.sv
// ----------------------------------------------------------------------------
// pfc_dp
// Payload buffer, header registers, frame sequencer, CRC and output beat.
// ----------------------------------------------------------------------------
module pfc_dp #(
   parameter int PAYLOAD_BYTES = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfc_pkg::cmd_type     cmd,
   output pfc_pkg::status_type  status,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic [7:0]           req_data_byte,
   input  logic [7:0]           req_descriptor,
   input  logic [31:0]          req_timestamp,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_frame_last
);

   localparam int ADDR_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int FRAME_LEN = PAYLOAD_BYTES + pfc_pkg::HDR_BYTES + 2;
   localparam int POS_W     = $clog2(FRAME_LEN);

   localparam logic [POS_W-1:0] POS_DESC = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TS0  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_TS1  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_TS2  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_TS3  = POS_W'(5);
   localparam logic [POS_W-1:0] POS_PAY  = POS_W'(pfc_pkg::HDR_BYTES);
   localparam logic [POS_W-1:0] POS_CRCL = POS_W'(PAYLOAD_BYTES + pfc_pkg::HDR_BYTES);
   localparam logic [POS_W-1:0] POS_CRCH = POS_W'(FRAME_LEN - 1);
   localparam logic [POS_W-1:0] POS_ZERO = '0;

   logic [7:0]        magic_ff, desc_ff;
   logic [31:0]       ts_ff;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in, rd_off;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        byte_ff, byte_sel;
   logic              last_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   assign status.fill_last = (fill_ff == ADDR_W'(PAYLOAD_BYTES - 1));
   assign status.pos_last  = (pos_ff == POS_CRCH);

   // fill pointer wraps to zero on the beat that completes the payload
   always_comb begin
      fill_in = fill_ff;
      if (cmd.write) begin
         fill_in = status.fill_last ? '0 : fill_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.emit) begin
         pos_in = status.pos_last ? POS_ZERO : pos_ff + POS_W'(1);
      end
   end

   // read one beat ahead so payload data lines up with pos_ff
   assign rd_off  = pos_in - POS_PAY;
   assign rd_addr = (pos_in >= POS_PAY && pos_in < POS_CRCL) ? rd_off[ADDR_W-1:0] : '0;

   pfc_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (fill_ff),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (pos_ff == POS_ZERO)        byte_sel = magic_ff;
      else if (pos_ff == POS_DESC)   byte_sel = desc_ff;
      else if (pos_ff == POS_TS0)    byte_sel = ts_ff[7:0];
      else if (pos_ff == POS_TS1)    byte_sel = ts_ff[15:8];
      else if (pos_ff == POS_TS2)    byte_sel = ts_ff[23:16];
      else if (pos_ff == POS_TS3)    byte_sel = ts_ff[31:24];
      else if (pos_ff == POS_CRCL)   byte_sel = crc_ff[7:0];
      else if (pos_ff == POS_CRCH)   byte_sel = crc_ff[15:8];
      else                           byte_sel = rd_data;
   end

   // CRC covers everything ahead of the CRC bytes; restarts for next frame
   always_comb begin
      crc_in = crc_ff;
      if (cmd.emit) begin
         if (status.pos_last) begin
            crc_in = pfc_pkg::CRC_INIT;
         end else if (pos_ff < POS_CRCL) begin
            crc_in = pfc_pkg::crc_byte(crc_ff, byte_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= pfc_pkg::MAGIC_RESET;
         desc_ff  <= '0;
         ts_ff    <= '0;
         fill_ff  <= '0;
         pos_ff   <= '0;
         crc_ff   <= pfc_pkg::CRC_INIT;
      end else begin
         if (csr_wr_en) begin
            magic_ff <= csr_wr_data;
         end
         if (cmd.write && fill_ff == '0) begin
            desc_ff <= req_descriptor;
            ts_ff   <= req_timestamp;
         end
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         byte_ff <= byte_sel;
         last_ff <= status.pos_last;
      end
   end

   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_last = last_ff;

endmodule
